FILE: hdl/trs_pkg.sv
// ----------------------------------------------------------------------------
// trs_pkg
// Shared constants, types and the Q30 multiply for the model matrix composer.
// ----------------------------------------------------------------------------
package trs_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int ANGLE_W         = 16;
    localparam int POS_W           = 32;
    localparam int SCALE_W         = 24;
    localparam int ENTRY_W         = 32;

    // pi/180 in Q32
    localparam logic [26:0] DEG_TO_RAD_Q32 = 27'd74961321;

    localparam int LANE_LAT  = 15;
    localparam int MERGE_LAT = 3;
    localparam int PIPE_LAT  = LANE_LAT + MERGE_LAT;

    localparam int IN_W  = 3 * POS_W + 3 * ANGLE_W + 3 * SCALE_W;
    localparam int OUT_W = 12 * ENTRY_W;

    typedef logic signed [31:0] q30_t;

    typedef struct packed {
        q30_t s;
        q30_t c;
    } sincos_t;

    // Q30 product, rounded to nearest with ties upward
    function automatic q30_t qmul(input q30_t a, input q30_t b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b) + (64'sd1 <<< 29);
        return 32'(p >>> 30);
    endfunction

endpackage

FILE: hdl/trs_model_matrix_compose_unit.sv
// ----------------------------------------------------------------------------
// trs_model_matrix_compose_unit
// Model matrix T*Rx*Ry*Rz*S composer (fixed point), one per cycle unstalled.
// ----------------------------------------------------------------------------
// Input stream (s_*): one transaction carries position, three Euler angles in
// 1/64 degree and three scale factors. Output stream (m_*): one transaction
// carries the top three rows of the affine matrix, column-major, Q16.16.
// Throughput: one transaction per cycle while not stalled. Three sin/cos
// lanes work on the three angles side by side (15 stages each, set by the
// Horner chain of five multiply and divide steps); a three-stage merge forms
// the rotation products, scales the columns and saturates.
// Stall: the whole pipeline holds while m_tvalid is high and m_tready low;
// s_tready then drops in the same cycle. The output register is the last
// pipeline stage, so an accepted input never waits on a free output slot.
// Reset: aresetn low clears all valid flags; no result appears until new
// input is accepted. Data registers are not reset.
// ----------------------------------------------------------------------------
module trs_model_matrix_compose_unit import trs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    output logic             s_tready,
    // pos_x, pos_y, pos_z, angle_x, angle_y, angle_z, scale_x, scale_y, scale_z
    input  logic [IN_W-1:0]  s_tdata,
    output logic             m_tvalid,
    input  logic             m_tready,
    // row0_col0, row1_col0, row2_col0, row0_col1, row1_col1, row2_col1,
    // row0_col2, row1_col2, row2_col2, row0_col3, row1_col3, row2_col3
    output logic [OUT_W-1:0] m_tdata
);
    localparam int ANG_OFS = 3 * POS_W;
    localparam int SCL_OFS = ANG_OFS + 3 * ANGLE_W;

    logic ce;
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    logic [PIPE_LAT-1:0] vld_reg, vld_next;
    assign vld_next = {vld_reg[PIPE_LAT-2:0], s_tvalid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= vld_next;
        end
    end
    assign m_tvalid = vld_reg[PIPE_LAT-1];

    // angle lanes
    sincos_t sc [3];
    for (genvar i = 0; i < 3; i++) begin : g_lane
        trs_sincos_lane u_lane (
            .aclk  (aclk),
            .ce    (ce),
            .angle (s_tdata[ANG_OFS + i*ANGLE_W +: ANGLE_W]),
            .sc    (sc[i])
        );
    end

    // side payload delay lines
    logic [3*SCALE_W-1:0] scl_dly_reg [LANE_LAT];
    logic [3*POS_W-1:0]   pos_dly_reg [PIPE_LAT];

    always_ff @(posedge aclk) begin
        if (ce) begin
            scl_dly_reg[0] <= s_tdata[SCL_OFS +: 3*SCALE_W];
            pos_dly_reg[0] <= s_tdata[0 +: 3*POS_W];
            for (int i = 1; i < LANE_LAT; i++) begin
                scl_dly_reg[i] <= scl_dly_reg[i-1];
            end
            for (int i = 1; i < PIPE_LAT; i++) begin
                pos_dly_reg[i] <= pos_dly_reg[i-1];
            end
        end
    end

    logic [3*SCALE_W-1:0] scl_al;
    assign scl_al = scl_dly_reg[LANE_LAT-1];

    logic [9*ENTRY_W-1:0] entries;

    trs_rot_merge u_merge (
        .aclk    (aclk),
        .ce      (ce),
        .scx     (sc[0]),
        .scy     (sc[1]),
        .scz     (sc[2]),
        .scale_x (scl_al[0*SCALE_W +: SCALE_W]),
        .scale_y (scl_al[1*SCALE_W +: SCALE_W]),
        .scale_z (scl_al[2*SCALE_W +: SCALE_W]),
        .entries (entries)
    );

    assign m_tdata = {pos_dly_reg[PIPE_LAT-1], entries};

endmodule

FILE: hdl/trs_horner_step.sv
// ----------------------------------------------------------------------------
// trs_horner_step
// One Horner step t' = 1 - ((x2*t) >> 30) / DIVISOR in Q30, two stages.
// ----------------------------------------------------------------------------
module trs_horner_step #(
    parameter int DIVISOR = 2
) (
    input  logic        aclk,
    input  logic        ce,
    input  logic [29:0] x2_i,
    input  logic [30:0] t_i,
    output logic [29:0] x2_o,
    output logic [30:0] t_o
);
    // exact floor division of a 31 bit value by reciprocal multiply
    localparam int RSH = 31 + $clog2(DIVISOR);
    localparam logic [32:0] RECIP =
        33'(((longint'(1) << RSH) + longint'(DIVISOR) - 1) / longint'(DIVISOR));

    logic [60:0] prod1;
    logic [63:0] prod2;
    logic [30:0] n_reg, n_next;
    logic [30:0] quo;
    logic [29:0] x2_mid_reg;
    logic [29:0] x2_out_reg;
    logic [30:0] t_reg, t_next;

    assign prod1  = 61'(x2_i) * 61'(t_i);
    assign n_next = prod1[60:30];
    assign prod2  = 64'(n_reg) * 64'(RECIP);
    assign quo    = 31'(prod2 >> RSH);
    assign t_next = (31'd1 << 30) - quo;

    always_ff @(posedge aclk) begin
        if (ce) begin
            n_reg      <= n_next;
            x2_mid_reg <= x2_i;
            t_reg      <= t_next;
            x2_out_reg <= x2_mid_reg;
        end
    end

    assign x2_o = x2_out_reg;
    assign t_o  = t_reg;

endmodule

FILE: hdl/trs_sincos_lane.sv
// ----------------------------------------------------------------------------
// trs_sincos_lane
// Angle lane: wraps one angle, reduces it to an octant and returns sin and
// cos in Q30. Fully pipelined.
// ----------------------------------------------------------------------------
module trs_sincos_lane import trs_pkg::*; (
    input  logic                      aclk,
    input  logic                      ce,
    input  logic signed [ANGLE_W-1:0] angle,
    output sincos_t                   sc
);
    localparam int PERIOD  = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER = 90 << ANGLE_FRAC_BITS;
    localparam int EIGHTH  = 45 << ANGLE_FRAC_BITS;
    localparam int MW      = $clog2(PERIOD);
    localparam int VW      = MW + 3;
    localparam int UW      = $clog2(EIGHTH + 1);
    localparam int PW      = UW + 27;
    localparam int RSH     = ANGLE_FRAC_BITS + 2;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam int SIN_STEPS = 4;
    localparam int COS_STEPS = 5;
    localparam int SIN_DIV [SIN_STEPS] = '{72, 42, 20, 6};
    localparam int COS_DIV [COS_STEPS] = '{90, 56, 30, 12, 2};
    localparam int QD_LEN = 12;
    localparam int XD_LEN = 9;

    // stage A: wrap into one turn (two periods added make every angle positive)
    logic [VW-1:0] v, v1;
    logic [MW-1:0] m_reg, m_next;

    assign v      = VW'(angle) + VW'(2 * PERIOD);
    assign v1     = (v >= VW'(2 * PERIOD)) ? v - VW'(2 * PERIOD) : v;
    assign m_next = MW'((v1 >= VW'(PERIOD)) ? v1 - VW'(PERIOD) : v1);

    // stage B: quadrant and octant fold
    logic [1:0]    q_reg, q_next;
    logic          swap_reg, swap_next;
    logic [UW-1:0] u_reg, u_next;
    logic [MW-1:0] r;

    always_comb begin
        priority if (m_reg >= MW'(3 * QUARTER)) begin
            q_next = QUAD_3;
            r      = m_reg - MW'(3 * QUARTER);
        end else if (m_reg >= MW'(2 * QUARTER)) begin
            q_next = QUAD_2;
            r      = m_reg - MW'(2 * QUARTER);
        end else if (m_reg >= MW'(QUARTER)) begin
            q_next = QUAD_1;
            r      = m_reg - MW'(QUARTER);
        end else begin
            q_next = QUAD_0;
            r      = m_reg;
        end
        swap_next = (r > MW'(EIGHTH));
        u_next    = swap_next ? UW'(MW'(QUARTER) - r) : UW'(r);
    end

    // stage C: radians in Q30; stage D: x squared
    logic [PW-1:0] rad_prod;
    logic [29:0]   x_reg, x_next;
    logic [59:0]   xx;
    logic [29:0]   x2_reg;

    assign rad_prod = PW'(u_reg) * PW'(DEG_TO_RAD_Q32) + PW'(1 << (RSH - 1));
    assign x_next   = 30'(rad_prod >> RSH);
    assign xx       = 60'(x_reg) * 60'(x_reg);

    logic [1:0]  qd_reg [QD_LEN];
    logic        sd_reg [QD_LEN];
    logic [29:0] xd_reg [XD_LEN];

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_reg    <= m_next;
            q_reg    <= q_next;
            swap_reg <= swap_next;
            u_reg    <= u_next;
            x_reg    <= x_next;
            x2_reg   <= xx[59:30];
            qd_reg[0] <= q_reg;
            sd_reg[0] <= swap_reg;
            xd_reg[0] <= x_reg;
            for (int i = 1; i < QD_LEN; i++) begin
                qd_reg[i] <= qd_reg[i-1];
                sd_reg[i] <= sd_reg[i-1];
            end
            for (int i = 1; i < XD_LEN; i++) begin
                xd_reg[i] <= xd_reg[i-1];
            end
        end
    end

    // Horner chains
    logic [29:0] sx2 [SIN_STEPS+1];
    logic [30:0] st  [SIN_STEPS+1];
    logic [29:0] cx2 [COS_STEPS+1];
    logic [30:0] ct  [COS_STEPS+1];

    assign sx2[0] = x2_reg;
    assign st[0]  = 31'd1 << 30;
    assign cx2[0] = x2_reg;
    assign ct[0]  = 31'd1 << 30;

    for (genvar i = 0; i < SIN_STEPS; i++) begin : g_sin
        trs_horner_step #(.DIVISOR(SIN_DIV[i])) u_step (
            .aclk (aclk),
            .ce   (ce),
            .x2_i (sx2[i]),
            .t_i  (st[i]),
            .x2_o (sx2[i+1]),
            .t_o  (st[i+1])
        );
    end

    for (genvar i = 0; i < COS_STEPS; i++) begin : g_cos
        trs_horner_step #(.DIVISOR(COS_DIV[i])) u_step (
            .aclk (aclk),
            .ce   (ce),
            .x2_i (cx2[i]),
            .t_i  (ct[i]),
            .x2_o (cx2[i+1]),
            .t_o  (ct[i+1])
        );
    end

    // sin = x * t, then one pad stage to line up with the longer cos chain
    logic [60:0] sp;
    logic [30:0] sin_reg, sin_pad_reg;
    assign sp = 61'(xd_reg[XD_LEN-1]) * 61'(st[SIN_STEPS]);

    logic  sw;
    q30_t  ps, pc;
    q30_t  s_next, c_next;
    sincos_t sc_reg;

    assign sw = sd_reg[QD_LEN-1];
    assign ps = sw ? q30_t'(ct[COS_STEPS]) : q30_t'(sin_pad_reg);
    assign pc = sw ? q30_t'(sin_pad_reg)   : q30_t'(ct[COS_STEPS]);

    always_comb begin
        unique case (qd_reg[QD_LEN-1])
            QUAD_0: begin s_next = ps;  c_next = pc;  end
            QUAD_1: begin s_next = pc;  c_next = -ps; end
            QUAD_2: begin s_next = -ps; c_next = -pc; end
            QUAD_3: begin s_next = -pc; c_next = ps;  end
            default: begin s_next = ps; c_next = pc;  end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            sin_reg     <= sp[60:30];
            sin_pad_reg <= sin_reg;
            sc_reg.s    <= s_next;
            sc_reg.c    <= c_next;
        end
    end

    assign sc = sc_reg;

endmodule

FILE: hdl/trs_rot_merge.sv
// ----------------------------------------------------------------------------
// trs_rot_merge
// Combines the three lanes into Rx*Ry*Rz, scales each column and saturates.
// Three stages.
// ----------------------------------------------------------------------------
module trs_rot_merge import trs_pkg::*; (
    input  logic                      aclk,
    input  logic                      ce,
    input  sincos_t                   scx,
    input  sincos_t                   scy,
    input  sincos_t                   scz,
    input  logic signed [SCALE_W-1:0] scale_x,
    input  logic signed [SCALE_W-1:0] scale_y,
    input  logic signed [SCALE_W-1:0] scale_z,
    output logic [9*ENTRY_W-1:0]      entries
);
    // stage 1: pairwise products
    q30_t cycz_reg, cysz_reg, sxsy_reg, cxsz_reg, cxcz_reg;
    q30_t sxcy_reg, sxsz_reg, cxsy_reg, sxcz_reg, cxcy_reg;
    q30_t sy_reg, cz_reg, sz_reg;
    logic signed [SCALE_W-1:0] scl1_reg [3];
    logic signed [SCALE_W-1:0] scl2_reg [3];

    // stage 2: rotation entries, row-major
    logic signed [32:0] rot_reg [9];
    logic signed [32:0] rot_next [9];

    always_comb begin
        rot_next[0] = 33'(cycz_reg);
        rot_next[1] = -33'(cysz_reg);
        rot_next[2] = 33'(sy_reg);
        rot_next[3] = 33'(qmul(sxsy_reg, cz_reg)) + 33'(cxsz_reg);
        rot_next[4] = 33'(cxcz_reg) - 33'(qmul(sxsy_reg, sz_reg));
        rot_next[5] = -33'(sxcy_reg);
        rot_next[6] = 33'(sxsz_reg) - 33'(qmul(cxsy_reg, cz_reg));
        rot_next[7] = 33'(qmul(cxsy_reg, sz_reg)) + 33'(sxcz_reg);
        rot_next[8] = 33'(cxcy_reg);
    end

    // stage 3: scale and saturate
    logic [ENTRY_W-1:0] ent_reg  [9];
    logic [ENTRY_W-1:0] ent_next [9];

    always_comb begin
        logic signed [63:0] p;
        logic signed [63:0] v;
        for (int i = 0; i < 9; i++) begin
            p = 64'(rot_reg[i]) * 64'(scl2_reg[i % 3]) + (64'sd1 <<< 29);
            v = p >>> 30;
            if (v > 64'sd2147483647) begin
                ent_next[i] = 32'h7FFF_FFFF;
            end else if (v < -64'sd2147483648) begin
                ent_next[i] = 32'h8000_0000;
            end else begin
                ent_next[i] = v[31:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ce) begin
            cycz_reg <= qmul(scy.c, scz.c);
            cysz_reg <= qmul(scy.c, scz.s);
            sxsy_reg <= qmul(scx.s, scy.s);
            cxsz_reg <= qmul(scx.c, scz.s);
            cxcz_reg <= qmul(scx.c, scz.c);
            sxcy_reg <= qmul(scx.s, scy.c);
            sxsz_reg <= qmul(scx.s, scz.s);
            cxsy_reg <= qmul(scx.c, scy.s);
            sxcz_reg <= qmul(scx.s, scz.c);
            cxcy_reg <= qmul(scx.c, scy.c);
            sy_reg   <= scy.s;
            cz_reg   <= scz.c;
            sz_reg   <= scz.s;
            scl1_reg[0] <= scale_x;
            scl1_reg[1] <= scale_y;
            scl1_reg[2] <= scale_z;
            for (int i = 0; i < 3; i++) begin
                scl2_reg[i] <= scl1_reg[i];
            end
            for (int i = 0; i < 9; i++) begin
                rot_reg[i] <= rot_next[i];
                ent_reg[i] <= ent_next[i];
            end
        end
    end

    // column-major: column c, row r at c*3+r
    for (genvar c = 0; c < 3; c++) begin : g_col
        for (genvar r = 0; r < 3; r++) begin : g_row
            assign entries[(c*3+r)*ENTRY_W +: ENTRY_W] = ent_reg[r*3+c];
        end
    end

endmodule

FILE: hdl/trs_mtx_checker.sv
// ----------------------------------------------------------------------------
// trs_mtx_checker
// Port-level checks for the model matrix composer, bound to the top level.
// ----------------------------------------------------------------------------
module trs_mtx_checker import trs_pkg::*; (
    input logic             aclk,
    input logic             aresetn,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic [IN_W-1:0]  s_tdata,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata
);
    // nothing comes out in the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // an empty output slot never back-pressures the input
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with no pending result");

    // a stalled result stays
    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped under stall");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed under stall");

    // an offered input transaction carries known data
    a_in_known: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid |-> !$isunknown(s_tdata))
        else $error("unknown input data offered");

endmodule

bind trs_model_matrix_compose_unit trs_mtx_checker u_trs_mtx_checker (.*);

FILE: dv/tb_trs_model_matrix_compose_unit.sv
// ----------------------------------------------------------------------------
// tb_trs_model_matrix_compose_unit
// Self-checking bench for the model matrix composer: directed corner rows then
// random transactions with random idling on both sides, results compared
// field by field against an in-bench fixed-point predictor.
// ----------------------------------------------------------------------------
module tb_trs_model_matrix_compose_unit;
    import trs_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int N_RANDOM = 1300;
    localparam int LONG_HOLD = 200;
    localparam int DRAIN_CYCLES = PIPE_LAT + 40;
    localparam int BURST_LEN = 60;

    localparam logic signed [31:0] ENT_MAX = 32'sh7fffffff;
    localparam logic signed [31:0] ENT_MIN = -32'sh7fffffff - 1;

    typedef struct packed {
        logic signed [23:0] scale_z;
        logic signed [23:0] scale_y;
        logic signed [23:0] scale_x;
        logic signed [15:0] ang_z;
        logic signed [15:0] ang_y;
        logic signed [15:0] ang_x;
        logic signed [31:0] pos_z;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_x;
    } pose_t;

    // entry[col*3+row], entries 9..11 are the translation
    typedef logic [11:0][31:0] matrix_t;

    typedef struct {
        pose_t   pose;
        bit      has_fixed;
        matrix_t fixed;
    } pose_row_t;

    logic            aclk = 1'b0;
    logic            aresetn = 1'b0;
    logic            s_tvalid = 1'b0;
    logic            s_tready;
    logic [IN_W-1:0] s_tdata = '0;
    logic            m_tvalid;
    logic            m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    matrix_t   matrix_queue[$];
    pose_row_t directed_rows[$];
    int        error_count = 0;
    bit        long_hold_req = 1'b0;

    always #4 aclk = ~aclk;

    trs_model_matrix_compose_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    function automatic longint rnd_shift(longint p, int n);
        longint q;
        q = p + (64'sd1 <<< (n - 1));
        return q >>> n;
    endfunction

    function automatic longint q30_mul(longint a, longint b);
        return rnd_shift(a * b, 30);
    endfunction

    function automatic void horner_sin_cos(longint x, output longint s, output longint c);
        longint one, x2, t;
        one = 64'sd1 <<< 30;
        x2 = (x * x) >>> 30;
        t = one - x2 / 72;
        t = one - ((x2 * t) >>> 30) / 42;
        t = one - ((x2 * t) >>> 30) / 20;
        t = one - ((x2 * t) >>> 30) / 6;
        s = (x * t) >>> 30;
        t = one - x2 / 90;
        t = one - ((x2 * t) >>> 30) / 56;
        t = one - ((x2 * t) >>> 30) / 30;
        t = one - ((x2 * t) >>> 30) / 12;
        t = one - ((x2 * t) >>> 30) / 2;
        c = t;
    endfunction

    function automatic void angle_trig(logic signed [15:0] ang, output longint s,
                                       output longint c);
        longint turn, quarter, eighth, m, q, r, ps, pc, ts, tc;
        turn = 360 << ANGLE_FRAC_BITS;
        quarter = 90 << ANGLE_FRAC_BITS;
        eighth = 45 << ANGLE_FRAC_BITS;
        m = longint'(ang) % turn;
        if (m < 0) m += turn;
        q = m / quarter;
        r = m - q * quarter;
        if (r <= eighth) begin
            horner_sin_cos(rnd_shift(r * 74961321, ANGLE_FRAC_BITS + 2), ps, pc);
        end else begin
            horner_sin_cos(rnd_shift((quarter - r) * 74961321, ANGLE_FRAC_BITS + 2), ts, tc);
            ps = tc;
            pc = ts;
        end
        case (q)
            0: begin s = ps;  c = pc;  end
            1: begin s = pc;  c = -ps; end
            2: begin s = -ps; c = -pc; end
            default: begin s = -pc; c = ps; end
        endcase
    endfunction

    function automatic logic [31:0] scale_sat(longint r, longint scl);
        longint v;
        v = rnd_shift(r * scl, 30);
        if (v > longint'(ENT_MAX)) v = ENT_MAX;
        if (v < longint'(ENT_MIN)) v = ENT_MIN;
        return v[31:0];
    endfunction

    function automatic matrix_t compose_matrix(pose_t p);
        longint sx, cx, sy, cy, sz, cz;
        longint rot[3][3];
        longint scl[3];
        matrix_t mtx;
        angle_trig(p.ang_x, sx, cx);
        angle_trig(p.ang_y, sy, cy);
        angle_trig(p.ang_z, sz, cz);
        scl[0] = p.scale_x;
        scl[1] = p.scale_y;
        scl[2] = p.scale_z;
        rot[0][0] = q30_mul(cy, cz);
        rot[0][1] = -q30_mul(cy, sz);
        rot[0][2] = sy;
        rot[1][0] = q30_mul(q30_mul(sx, sy), cz) + q30_mul(cx, sz);
        rot[1][1] = q30_mul(cx, cz) - q30_mul(q30_mul(sx, sy), sz);
        rot[1][2] = -q30_mul(sx, cy);
        rot[2][0] = q30_mul(sx, sz) - q30_mul(q30_mul(cx, sy), cz);
        rot[2][1] = q30_mul(q30_mul(cx, sy), sz) + q30_mul(sx, cz);
        rot[2][2] = q30_mul(cx, cy);
        for (int col = 0; col < 3; col++)
            for (int row = 0; row < 3; row++)
                mtx[col * 3 + row] = scale_sat(rot[row][col], scl[col]);
        mtx[9] = p.pos_x;
        mtx[10] = p.pos_y;
        mtx[11] = p.pos_z;
        return mtx;
    endfunction

    task automatic report_mismatch(string what);
        $display("ERROR %0t: %s", $realtime, what);
        error_count++;
    endtask

    function automatic pose_t random_pose();
        pose_t p;
        p = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
        case ($urandom_range(0, 3))
            // half the time: ordinary scales from -2 to 2
            0, 1: begin
                p.scale_x = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                p.scale_y = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
                p.scale_z = 24'($signed($urandom_range(0, 1 << 18)) - (1 << 17));
            end
            // angles on multiples of 45 degrees
            2: begin
                p.ang_x = 16'(($urandom_range(0, 16) - 8) * (45 << ANGLE_FRAC_BITS));
                p.ang_y = 16'(($urandom_range(0, 16) - 8) * (45 << ANGLE_FRAC_BITS));
                p.ang_z = 16'(($urandom_range(0, 16) - 8) * (45 << ANGLE_FRAC_BITS));
            end
            default: ;
        endcase
        return p;
    endfunction

    function automatic pose_t make_pose(int ax, int ay, int az, int sx, int sy, int sz,
                                        int px, int py, int pz);
        pose_t p;
        p.ang_x = 16'(ax);
        p.ang_y = 16'(ay);
        p.ang_z = 16'(az);
        p.scale_x = 24'(sx);
        p.scale_y = 24'(sy);
        p.scale_z = 24'(sz);
        p.pos_x = px;
        p.pos_y = py;
        p.pos_z = pz;
        return p;
    endfunction

    function automatic matrix_t diag_matrix(int d, int px, int py, int pz);
        matrix_t m;
        m = '0;
        m[0] = d;
        m[4] = d;
        m[8] = d;
        m[9] = px;
        m[10] = py;
        m[11] = pz;
        return m;
    endfunction

    task automatic add_row(pose_t p, bit fixed_ok, matrix_t m);
        pose_row_t r;
        r.pose = p;
        r.has_fixed = fixed_ok;
        r.fixed = m;
        directed_rows.push_back(r);
    endtask

    task automatic build_directed_rows();
        int one;
        int deg;
        one = 1 << 16;
        deg = 1 << ANGLE_FRAC_BITS;
        // identity rotation, unit scale: readable at a glance
        add_row(make_pose(0, 0, 0, one, one, one, 0, 0, 0), 1, diag_matrix(one, 0, 0, 0));
        add_row(make_pose(0, 0, 0, one, one, one, 32'h7fffffff, 32'h80000000, -1), 1,
                diag_matrix(one, 32'h7fffffff, 32'h80000000, -1));
        // zero scale collapses every column
        add_row(make_pose(1234, -777, 9999, 0, 0, 0, 5, 6, 7), 1, diag_matrix(0, 5, 6, 7));
        // a full turn wraps back to identity
        add_row(make_pose(360 * deg, -360 * deg, 0, one, one, one, 1, 2, 3), 1,
                diag_matrix(one, 1, 2, 3));
        // largest positive scale is exactly 128 - lsb on the diagonal
        add_row(make_pose(0, 0, 0, 24'h7fffff, 24'h7fffff, 24'h7fffff, 0, 0, 0), 1,
                diag_matrix(32'h007fffff, 0, 0, 0));
        add_row(make_pose(0, 0, 0, 24'h800000, 24'h800000, 24'h800000, 0, 0, 0), 1,
                diag_matrix(32'hff800000, 0, 0, 0));
        // extremes of the angle fields, quadrants and the octant split
        add_row(make_pose(32767, -32768, 32767, one, -one, one, 0, 0, 0), 0, '0);
        add_row(make_pose(-32768, 32767, -32768, -one, one, -one, 0, 0, 0), 0, '0);
        add_row(make_pose(90 * deg, 0, 0, one, one, one, 0, 0, 0), 0, '0);
        add_row(make_pose(0, 180 * deg, 0, one, one, one, 0, 0, 0), 0, '0);
        add_row(make_pose(0, 0, 270 * deg, one, one, one, 0, 0, 0), 0, '0);
        add_row(make_pose(45 * deg, 45 * deg + 1, 45 * deg - 1, one, one, one, 0, 0, 0),
                0, '0);
        add_row(make_pose(-1, 1, -90 * deg, one, one, one, 0, 0, 0), 0, '0);
        add_row(make_pose(30 * deg, 60 * deg, 135 * deg, 24'h7fffff, 24'h800000,
                          24'h7fffff, 0, 0, 0), 0, '0);
        add_row(make_pose(200 * deg, -100 * deg, 315 * deg, -3 * one, 2 * one, one / 2,
                          32'h12345678, 32'hedcba987, 0), 0, '0);
        add_row(make_pose(-45 * deg, 0, 359 * deg + 63, 1, -1, 1, 0, 0, 0), 0, '0);
    endtask

    // valid only drops when an idle gap follows, so back-to-back stays one assignment
    task automatic send_pose(pose_t p, bit no_idle);
        int gap;
        gap = no_idle ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12));
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= p;
        matrix_queue.push_back(compose_matrix(p));
        do @(posedge aclk); while (!s_tready);
    endtask

    // sender
    initial begin
        pose_row_t r;
        build_directed_rows();
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        foreach (directed_rows[i]) begin
            r = directed_rows[i];
            if (r.has_fixed && compose_matrix(r.pose) != r.fixed)
                report_mismatch($sformatf("directed row %0d: predictor disagrees", i));
            send_pose(r.pose, 1'b0);
        end
        s_tvalid <= 1'b0;
        // pause until everything has drained
        wait (matrix_queue.size() == 0);
        long_hold_req = 1'b1;
        // opening burst runs back to back while the receiver holds off
        for (int i = 0; i < N_RANDOM; i++)
            send_pose(random_pose(), i < BURST_LEN);
        s_tvalid <= 1'b0;
        wait (matrix_queue.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // receiver
    initial begin
        int gap;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 12);
            if (gap != 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    // checker: samples at the edge, values settled from the previous step
    always @(posedge aclk) begin
        matrix_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (matrix_queue.size() == 0) begin
                report_mismatch("result transaction with nothing expected");
            end else begin
                want = matrix_queue.pop_front();
                for (int k = 0; k < 12; k++)
                    if (got[k] != want[k])
                        report_mismatch($sformatf("row%0d_col%0d got %h want %h",
                                                  k % 3, k / 3, got[k], want[k]));
            end
        end
    end

    initial begin
        #20ms;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
